// ===== rtl/fmcdp_pkg.sv =====
package fmcdp_pkg;

    localparam int COORD_SIZE = 64;
    localparam int MAX_ITEMS  = 1024;

    localparam int COORD_W = 7;
    localparam int VALUE_W = 32;
    localparam int TOTAL_W = 48;
    localparam int POS_W   = 11;

    // Walk indices reach up to twice the coordinate range while stepping upward.
    localparam int IDX_W      = $clog2(2 * COORD_SIZE + 1);
    localparam int TREE_DEPTH = COORD_SIZE * COORD_SIZE;
    localparam int TREE_AW    = $clog2(TREE_DEPTH);
    localparam int TOT_DEPTH  = MAX_ITEMS + 1;
    localparam int TOT_AW     = $clog2(TOT_DEPTH);

    typedef struct packed {
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
        logic [VALUE_W-1:0] value;
    } t_in_beat;

    typedef struct packed {
        logic [TOTAL_W-1:0] chain_total;
        logic [POS_W-1:0]   parent_position;
        logic               full_res;
    } t_out_beat;

    typedef struct packed {
        logic clr_wr;
        logic load;
        logic tree_rd;
        logic tot_rd;
        logic q_step;
        logic sum;
        logic u_step;
        logic finish;
        logic full_out;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic full;
        logic zero_coord;
        logic q_last;
        logic u_last;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/fmcdp_dpath.sv =====
module fmcdp_dpath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fmcdp_pkg::t_in_beat  i_in,
    input  fmcdp_pkg::t_cmd      i_cmd,
    output fmcdp_pkg::t_sts      o_sts,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output fmcdp_pkg::t_out_beat o_out
);
    import fmcdp_pkg::*;

    logic [POS_W-1:0]   tree_mem [TREE_DEPTH];
    logic [TOTAL_W-1:0] tot_mem  [TOT_DEPTH];

    logic [IDX_W-1:0]   r_x, r_y, r_cx, r_cy;
    logic [VALUE_W-1:0] r_value;
    logic [POS_W-1:0]   r_pos, r_best, r_tree_q;
    logic [TOTAL_W-1:0] r_best_total, r_new_total, r_tot_q;
    logic [TREE_AW-1:0] r_clr_addr;
    logic               r_out_valid;
    t_out_beat          r_out;

    logic [IDX_W-1:0]   in_x, in_y, cx_dn, cy_dn, cx_up, cy_up;
    logic [TOTAL_W-1:0] cand_total, sat_total;
    logic [TOTAL_W:0]   raw_sum;
    logic [TREE_AW-1:0] cur_addr;
    logic               tree_upd;

    function automatic logic [TREE_AW-1:0] cell_addr(
        input logic [IDX_W-1:0] cx,
        input logic [IDX_W-1:0] cy
    );
        logic [TREE_AW-1:0] lin;
        lin = (TREE_AW'(cx) - TREE_AW'(1)) * TREE_AW'(COORD_SIZE)
            + TREE_AW'(cy) - TREE_AW'(1);
        return lin;
    endfunction

    // Saturate coordinates above the tree range.
    assign in_x = (IDX_W'(i_in.width) > IDX_W'(COORD_SIZE)) ? IDX_W'(COORD_SIZE)
                                                            : IDX_W'(i_in.width);
    assign in_y = (IDX_W'(i_in.height) > IDX_W'(COORD_SIZE)) ? IDX_W'(COORD_SIZE)
                                                             : IDX_W'(i_in.height);

    assign cx_dn = r_cx & (r_cx - IDX_W'(1));
    assign cy_dn = r_cy & (r_cy - IDX_W'(1));
    assign cx_up = r_cx + (r_cx & (~r_cx + IDX_W'(1)));
    assign cy_up = r_cy + (r_cy & (~r_cy + IDX_W'(1)));

    // Position zero is the empty entry and always weighs zero.
    assign cand_total = (r_tree_q == '0) ? '0 : r_tot_q;
    assign raw_sum    = {1'b0, r_best_total} + (TOTAL_W + 1)'(r_value);
    assign sat_total  = raw_sum[TOTAL_W] ? '1 : raw_sum[TOTAL_W-1:0];
    assign cur_addr   = cell_addr(r_cx, r_cy);
    assign tree_upd   = cand_total < r_new_total;

    assign o_sts.clr_last   = (r_clr_addr == TREE_AW'(TREE_DEPTH - 1));
    assign o_sts.full       = (r_pos > POS_W'(MAX_ITEMS));
    assign o_sts.zero_coord = (r_x == '0) || (r_y == '0);
    assign o_sts.q_last     = (cy_dn == '0) && (cx_dn == '0);
    assign o_sts.u_last     = (cy_up > IDX_W'(COORD_SIZE)) && (cx_up > IDX_W'(COORD_SIZE));
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            tree_mem[r_clr_addr] <= '0;
        end else if (i_cmd.u_step && tree_upd) begin
            tree_mem[cur_addr] <= r_pos;
        end
        if (i_cmd.tree_rd) begin
            r_tree_q <= tree_mem[cur_addr];
        end
        if (i_cmd.sum) begin
            tot_mem[r_pos[TOT_AW-1:0]] <= sat_total;
        end
        if (i_cmd.tot_rd) begin
            r_tot_q <= tot_mem[r_tree_q[TOT_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_pos       <= POS_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + TREE_AW'(1);
            end
            if (i_cmd.finish) begin
                r_pos <= r_pos + POS_W'(1);
            end
            if (i_cmd.finish || i_cmd.full_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x          <= in_x;
            r_y          <= in_y;
            r_cx         <= in_x;
            r_cy         <= in_y;
            r_value      <= i_in.value;
            r_best       <= '0;
            r_best_total <= '0;
        end
        if (i_cmd.q_step) begin
            // Strict compare: on a tie keep the entry found first.
            if (r_best_total < cand_total) begin
                r_best       <= r_tree_q;
                r_best_total <= cand_total;
            end
            if (cy_dn == '0) begin
                r_cx <= cx_dn;
                r_cy <= r_y;
            end else begin
                r_cy <= cy_dn;
            end
        end
        if (i_cmd.sum) begin
            r_new_total <= sat_total;
            r_cx        <= r_x;
            r_cy        <= r_y;
        end
        if (i_cmd.u_step) begin
            if (cy_up > IDX_W'(COORD_SIZE)) begin
                r_cx <= cx_up;
                r_cy <= r_y;
            end else begin
                r_cy <= cy_up;
            end
        end
        if (i_cmd.finish) begin
            r_out.chain_total     <= r_new_total;
            r_out.parent_position <= r_best;
            r_out.full_res        <= 1'b0;
        end else if (i_cmd.full_out) begin
            r_out.chain_total     <= '0;
            r_out.parent_position <= '0;
            r_out.full_res        <= 1'b1;
        end
    end

    a_best_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.q_step |=> r_best_total >= $past(r_best_total))
        else $error("best total dropped during query");

    a_parent_earlier: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> r_best < r_pos)
        else $error("parent is not an earlier box");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(MAX_ITEMS + 1))
        else $error("position counter past capacity");

    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.full_out |=> r_out.chain_total == '0 && r_out.parent_position == '0)
        else $error("capacity beat carries data");

endmodule

// ===== rtl/fmcdp_ctrl.sv =====
module fmcdp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  fmcdp_pkg::t_sts i_sts,
    output fmcdp_pkg::t_cmd o_cmd
);
    import fmcdp_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FRONT,
        S_QRD,
        S_QTOT,
        S_QCMP,
        S_SUM,
        S_URD,
        S_UTOT,
        S_UCMP,
        S_DONE,
        S_FULL
    } t_state;

    t_state r_state, n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_FRONT;
                end
            end
            S_FRONT: begin
                priority if (i_sts.full) begin
                    n_state = S_FULL;
                end else if (i_sts.zero_coord) begin
                    n_state = S_SUM;
                end else begin
                    n_state = S_QRD;
                end
            end
            S_QRD: begin
                o_cmd.tree_rd = 1'b1;
                n_state       = S_QTOT;
            end
            S_QTOT: begin
                o_cmd.tot_rd = 1'b1;
                n_state      = S_QCMP;
            end
            S_QCMP: begin
                o_cmd.q_step = 1'b1;
                n_state      = i_sts.q_last ? S_SUM : S_QRD;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = i_sts.zero_coord ? S_DONE : S_URD;
            end
            S_URD: begin
                o_cmd.tree_rd = 1'b1;
                n_state       = S_UTOT;
            end
            S_UTOT: begin
                o_cmd.tot_rd = 1'b1;
                n_state      = S_UCMP;
            end
            S_UCMP: begin
                o_cmd.u_step = 1'b1;
                n_state      = i_sts.u_last ? S_DONE : S_URD;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_FULL: begin
                if (i_sts.out_free) begin
                    o_cmd.full_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    a_read_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.tree_rd |=> o_cmd.tot_rd)
        else $error("tree read not followed by total read");

    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.finish || o_cmd.full_out) |-> i_sts.out_free)
        else $error("result overwrote a pending beat");

endmodule

// ===== rtl/fenwick_2d_max_chain_dp.sv =====
// Box-stacking chain step over a 2D Fenwick prefix maximum.
//
// Input channel (i_in_valid / o_in_stall / i_in): one beat per box, boxes
// pre-sorted by length, then width, then height. Each box takes the next
// position from 1. Output channel (o_out_valid / i_out_stall / o_out): one
// beat per box with its chain total, parent position and the capacity flag.
//
// Per box, the prefix query visits Nq tree cells (at most 36) and the update
// visits Nu (at most 49). Every cell costs a tree read followed by a dependent
// total read, both through the single read port of each memory. A box with a
// zero coordinate skips both walks; a box past capacity skips them and
// answers with the capacity flag. One box is in work at a time; the next is
// taken once the result sits in the output register.
//
// After reset the tree memory is swept to zero, one cell a cycle, over all
// 4096 cells; o_in_stall stays high meanwhile, and also for as long as a box
// is in work. A stalled result holds in the output register; a finished box
// waits for that register to free up before its result is written.
module fenwick_2d_max_chain_dp_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  fmcdp_pkg::t_in_beat  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output fmcdp_pkg::t_out_beat o_out
);
    import fmcdp_pkg::*;

    t_cmd cmd;
    t_sts sts;

    fmcdp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fmcdp_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule
